FILE: design/eba_pkg.sv
// Shared types, operation codes and constants for the eight-bit ALU with flags.
`default_nettype none

package eba_pkg;

    // Operation codes carried in the mode field.
    localparam logic [4:0] MODE_ADD  = 5'd0;
    localparam logic [4:0] MODE_ADC  = 5'd1;
    localparam logic [4:0] MODE_SUB  = 5'd2;
    localparam logic [4:0] MODE_SBC  = 5'd3;
    localparam logic [4:0] MODE_AND  = 5'd4;
    localparam logic [4:0] MODE_XOR  = 5'd5;
    localparam logic [4:0] MODE_OR   = 5'd6;
    localparam logic [4:0] MODE_CP   = 5'd7;
    localparam logic [4:0] MODE_INC  = 5'd8;
    localparam logic [4:0] MODE_DEC  = 5'd9;
    localparam logic [4:0] MODE_DAA  = 5'd10;
    localparam logic [4:0] MODE_CPL  = 5'd11;
    localparam logic [4:0] MODE_CCF  = 5'd12;
    localparam logic [4:0] MODE_RLC  = 5'd13;
    localparam logic [4:0] MODE_SWAP = 5'd20;
    localparam logic [4:0] MODE_BIT  = 5'd21;
    localparam logic [4:0] MODE_RES  = 5'd22;
    localparam logic [4:0] MODE_SET  = 5'd23;
    localparam logic [4:0] MODE_RLCA = 5'd24;
    localparam logic [4:0] MODE_RRA  = 5'd27;

    // Shift unit operation kinds.
    localparam logic [2:0] SH_RLC  = 3'd0;
    localparam logic [2:0] SH_RRC  = 3'd1;
    localparam logic [2:0] SH_RL   = 3'd2;
    localparam logic [2:0] SH_RR   = 3'd3;
    localparam logic [2:0] SH_SLA  = 3'd4;
    localparam logic [2:0] SH_SRA  = 3'd5;
    localparam logic [2:0] SH_SRL  = 3'd6;
    localparam logic [2:0] SH_SWAP = 3'd7;

    // Decimal adjust constants.
    localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
    localparam logic [7:0] BCD_BYTE_MAX  = 8'h99;
    localparam logic [7:0] DAA_LO_ADJ    = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ    = 8'h60;

    typedef struct packed {
        logic [4:0] mode;
        logic [7:0] a_value;
        logic [7:0] operand;
        logic [2:0] bit_index;
        logic       zero_in;
        logic       sub_in;
        logic       half_in;
        logic       carry_in;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic       zero_out;
        logic       sub_out;
        logic       half_out;
        logic       carry_out;
    } t_alu_out;

endpackage

`default_nettype wire

FILE: design/eba_shift.sv
// Rotate, shift and nibble swap unit with the bit shifted out as carry.
`default_nettype none

module eba_shift
    import eba_pkg::*;
(
    input  wire logic [2:0] i_kind,
    input  wire logic [7:0] i_value,
    input  wire logic       i_carry,
    output logic      [7:0] o_value,
    output logic            o_carry
);

    always_comb begin
        case (i_kind)
            SH_RLC: begin
                o_value = {i_value[6:0], i_value[7]};
                o_carry = i_value[7];
            end
            SH_RRC: begin
                o_value = {i_value[0], i_value[7:1]};
                o_carry = i_value[0];
            end
            SH_RL: begin
                o_value = {i_value[6:0], i_carry};
                o_carry = i_value[7];
            end
            SH_RR: begin
                o_value = {i_carry, i_value[7:1]};
                o_carry = i_value[0];
            end
            SH_SLA: begin
                o_value = {i_value[6:0], 1'b0};
                o_carry = i_value[7];
            end
            SH_SRA: begin
                o_value = {i_value[7], i_value[7:1]};
                o_carry = i_value[0];
            end
            SH_SRL: begin
                o_value = {1'b0, i_value[7:1]};
                o_carry = i_value[0];
            end
            default: begin
                o_value = {i_value[3:0], i_value[7:4]};
                o_carry = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/eba_core.sv
// Combinational ALU datapath: arithmetic, logic, decimal adjust, shifts and bit operations.
`default_nettype none

module eba_core
    import eba_pkg::*;
(
    input  wire t_alu_in  i_item,
    output t_alu_out      o_out
);

    logic       carry_use;
    logic [8:0] sum9;
    logic [4:0] sum_lo;
    logic [8:0] diff9;
    logic [4:0] diff_lo;
    logic [7:0] bit_mask;
    logic [7:0] daa_adj;
    logic       daa_hi;
    logic [7:0] sh_in;
    logic [4:0] sh_kind_full;
    logic [7:0] sh_out;
    logic       sh_carry;
    logic       is_acc_rot;

    always_comb begin
        carry_use = i_item.carry_in && (i_item.mode == MODE_ADC || i_item.mode == MODE_SBC);
        sum9    = {1'b0, i_item.a_value} + {1'b0, i_item.operand} + {8'd0, carry_use};
        sum_lo  = {1'b0, i_item.a_value[3:0]} + {1'b0, i_item.operand[3:0]}
                + {4'd0, carry_use};
        // Bit 8 and bit 4 of the differences are the full and half borrows.
        diff9   = {1'b0, i_item.a_value} - {1'b0, i_item.operand} - {8'd0, carry_use};
        diff_lo = {1'b0, i_item.a_value[3:0]} - {1'b0, i_item.operand[3:0]}
                - {4'd0, carry_use};
        bit_mask = 8'd1 << i_item.bit_index;
    end

    // Decimal adjust correction.
    always_comb begin
        daa_adj = 8'd0;
        daa_hi  = 1'b0;
        if (i_item.sub_in) begin
            if (i_item.half_in) begin
                daa_adj = daa_adj | DAA_LO_ADJ;
            end
            if (i_item.carry_in) begin
                daa_adj = daa_adj | DAA_HI_ADJ;
            end
        end else begin
            if (i_item.half_in || i_item.a_value[3:0] > BCD_DIGIT_MAX) begin
                daa_adj = daa_adj | DAA_LO_ADJ;
            end
            if (i_item.carry_in || i_item.a_value > BCD_BYTE_MAX) begin
                daa_adj = daa_adj | DAA_HI_ADJ;
                daa_hi  = 1'b1;
            end
        end
    end

    // One shift unit serves both the operand forms and the accumulator rotates.
    always_comb begin
        is_acc_rot   = (i_item.mode >= MODE_RLCA);
        sh_in        = is_acc_rot ? i_item.a_value : i_item.operand;
        sh_kind_full = is_acc_rot ? (i_item.mode - MODE_RLCA) : (i_item.mode - MODE_RLC);
    end

    eba_shift u_shift (
        .i_kind  (sh_kind_full[2:0]),
        .i_value (sh_in),
        .i_carry (i_item.carry_in),
        .o_value (sh_out),
        .o_carry (sh_carry)
    );

    always_comb begin
        o_out.result    = i_item.a_value;
        o_out.zero_out  = i_item.zero_in;
        o_out.sub_out   = i_item.sub_in;
        o_out.half_out  = i_item.half_in;
        o_out.carry_out = i_item.carry_in;
        case (i_item.mode) inside
            MODE_ADD, MODE_ADC: begin
                o_out.result    = sum9[7:0];
                o_out.zero_out  = (sum9[7:0] == 8'd0);
                o_out.sub_out   = 1'b0;
                o_out.half_out  = sum_lo[4];
                o_out.carry_out = sum9[8];
            end
            MODE_SUB, MODE_SBC, MODE_CP: begin
                // Compare keeps the accumulator but sets flags as a subtract.
                if (i_item.mode != MODE_CP) begin
                    o_out.result = diff9[7:0];
                end
                o_out.zero_out  = (diff9[7:0] == 8'd0);
                o_out.sub_out   = 1'b1;
                o_out.half_out  = diff_lo[4];
                o_out.carry_out = diff9[8];
            end
            MODE_AND: begin
                o_out.result    = i_item.a_value & i_item.operand;
                o_out.zero_out  = ((i_item.a_value & i_item.operand) == 8'd0);
                o_out.sub_out   = 1'b0;
                o_out.half_out  = 1'b1;
                o_out.carry_out = 1'b0;
            end
            MODE_XOR: begin
                o_out.result    = i_item.a_value ^ i_item.operand;
                o_out.zero_out  = ((i_item.a_value ^ i_item.operand) == 8'd0);
                o_out.sub_out   = 1'b0;
                o_out.half_out  = 1'b0;
                o_out.carry_out = 1'b0;
            end
            MODE_OR: begin
                o_out.result    = i_item.a_value | i_item.operand;
                o_out.zero_out  = ((i_item.a_value | i_item.operand) == 8'd0);
                o_out.sub_out   = 1'b0;
                o_out.half_out  = 1'b0;
                o_out.carry_out = 1'b0;
            end
            MODE_INC: begin
                o_out.result   = i_item.operand + 8'd1;
                o_out.zero_out = (i_item.operand == 8'hFF);
                o_out.sub_out  = 1'b0;
                o_out.half_out = (i_item.operand[3:0] == 4'hF);
            end
            MODE_DEC: begin
                o_out.result   = i_item.operand - 8'd1;
                o_out.zero_out = (i_item.operand == 8'd1);
                o_out.sub_out  = 1'b1;
                o_out.half_out = (i_item.operand[3:0] == 4'h0);
            end
            MODE_DAA: begin
                if (i_item.sub_in) begin
                    o_out.result   = i_item.a_value - daa_adj;
                    o_out.zero_out = ((i_item.a_value - daa_adj) == 8'd0);
                end else begin
                    o_out.result    = i_item.a_value + daa_adj;
                    o_out.zero_out  = ((i_item.a_value + daa_adj) == 8'd0);
                    o_out.carry_out = daa_hi;
                end
                o_out.half_out = 1'b0;
            end
            MODE_CPL: begin
                o_out.result   = ~i_item.a_value;
                o_out.sub_out  = 1'b1;
                o_out.half_out = 1'b1;
            end
            MODE_CCF: begin
                o_out.sub_out   = 1'b0;
                o_out.half_out  = 1'b0;
                o_out.carry_out = ~i_item.carry_in;
            end
            [MODE_RLC:MODE_SWAP]: begin
                o_out.result    = sh_out;
                o_out.zero_out  = (sh_out == 8'd0);
                o_out.sub_out   = 1'b0;
                o_out.half_out  = 1'b0;
                o_out.carry_out = sh_carry;
            end
            MODE_BIT: begin
                o_out.result   = i_item.operand;
                o_out.zero_out = ((i_item.operand & bit_mask) == 8'd0);
                o_out.sub_out  = 1'b0;
                o_out.half_out = 1'b1;
            end
            MODE_RES: begin
                o_out.result = i_item.operand & ~bit_mask;
            end
            MODE_SET: begin
                o_out.result = i_item.operand | bit_mask;
            end
            [MODE_RLCA:MODE_RRA]: begin
                o_out.result    = sh_out;
                o_out.zero_out  = 1'b0;
                o_out.sub_out   = 1'b0;
                o_out.half_out  = 1'b0;
                o_out.carry_out = sh_carry;
            end
            default: begin
                // Unused codes return the accumulator with all flags unchanged.
                o_out.result = i_item.a_value;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/eight_bit_alu_with_flags_top.sv
// Top level of the eight-bit ALU with flags: input register, datapath and result register.
// One item is accepted in every clock cycle at which start is high; busy never rises. The
// item is captured in an input register, passes through the combinational ALU datapath and
// lands in the result register, so each result appears on o_result with o_valid high for
// one cycle. Results come out in item order and are presented whether or not anyone takes
// them. The block keeps no state between items.
`default_nettype none

module eight_bit_alu_with_flags_top
    import eba_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_alu_in  i_item,
    output logic          o_valid,
    output t_alu_out      o_result
);

    t_alu_in  r_in;
    logic     r_in_valid;
    t_alu_out r_out;
    logic     r_out_valid;
    t_alu_out n_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
        r_out <= n_out;
    end

    eba_core u_core (
        .i_item (r_in),
        .o_out  (n_out)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_in_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_in_valid)
        else $error("Accepted item did not reach the input register.");

    a_out_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_valid)
        else $error("Item in the input register produced no result.");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_valid))
        else $error("Result strobe without a preceding item.");

    a_cp_keeps_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_in.mode) == MODE_CP) |-> o_result.result == $past(r_in.a_value))
        else $error("Compare changed the accumulator value.");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/eight_bit_alu_with_flags_top_tb.sv
// Self-checking testbench for the eight-bit ALU with flags: directed and random items.
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_top_tb;
    import eba_pkg::*;

    localparam int          CYCLE_LIMIT       = 60000;
    localparam int          ITEMS_PER_PHASE   = 463;
    localparam int          DRAIN_CYCLES      = 4;
    localparam logic [4:0]  MODE_FIRST_UNUSED = MODE_RRA + 5'd1;
    localparam logic [4:0]  MODE_LAST_UNUSED  = 5'd31;

    // Predicts the ALU outcome of each accepted item and checks the results in order.
    class alu_result_board;
        t_alu_out pending_results[$];
        int       items_noted;
        int       results_checked;
        int       mismatch_count;

        function new();
            items_noted     = 0;
            results_checked = 0;
            mismatch_count  = 0;
        endfunction

        function logic [7:0] shift_byte(input logic [2:0] kind, input logic [7:0] v,
                                        input logic cin, output logic cy);
            logic [7:0] r;
            case (kind)
                SH_RLC: begin
                    cy = v[7];
                    r  = {v[6:0], v[7]};
                end
                SH_RRC: begin
                    cy = v[0];
                    r  = {v[0], v[7:1]};
                end
                SH_RL: begin
                    cy = v[7];
                    r  = {v[6:0], cin};
                end
                SH_RR: begin
                    cy = v[0];
                    r  = {cin, v[7:1]};
                end
                SH_SLA: begin
                    cy = v[7];
                    r  = {v[6:0], 1'b0};
                end
                SH_SRA: begin
                    cy = v[0];
                    r  = {v[7], v[7:1]};
                end
                SH_SRL: begin
                    cy = v[0];
                    r  = {1'b0, v[7:1]};
                end
                default: begin
                    cy = 1'b0;
                    r  = {v[3:0], v[7:4]};
                end
            endcase
            return r;
        endfunction

        function t_alu_out predict_alu(input t_alu_in it);
            t_alu_out   res;
            logic [8:0] wide;
            logic [4:0] nib;
            logic [7:0] diff;
            logic [7:0] adj;
            logic [4:0] kind;
            logic       ci;
            logic       cy;
            // Flags that an operation leaves alone pass through.
            res.result    = it.a_value;
            res.zero_out  = it.zero_in;
            res.sub_out   = it.sub_in;
            res.half_out  = it.half_in;
            res.carry_out = it.carry_in;
            case (it.mode)
                MODE_ADD, MODE_ADC: begin
                    ci   = (it.mode == MODE_ADC) ? it.carry_in : 1'b0;
                    wide = {1'b0, it.a_value} + {1'b0, it.operand} + {8'd0, ci};
                    nib  = {1'b0, it.a_value[3:0]} + {1'b0, it.operand[3:0]} + {4'd0, ci};
                    res.result    = wide[7:0];
                    res.zero_out  = (wide[7:0] == 8'd0);
                    res.sub_out   = 1'b0;
                    res.half_out  = nib[4];
                    res.carry_out = wide[8];
                end
                MODE_SUB, MODE_SBC, MODE_CP: begin
                    ci   = (it.mode == MODE_SBC) ? it.carry_in : 1'b0;
                    diff = it.a_value - it.operand - {7'd0, ci};
                    res.result    = (it.mode == MODE_CP) ? it.a_value : diff;
                    res.zero_out  = (diff == 8'd0);
                    res.sub_out   = 1'b1;
                    res.half_out  = {1'b0, it.a_value[3:0]} <
                                    ({1'b0, it.operand[3:0]} + {4'd0, ci});
                    res.carry_out = {1'b0, it.a_value} < ({1'b0, it.operand} + {8'd0, ci});
                end
                MODE_AND, MODE_XOR, MODE_OR: begin
                    if (it.mode == MODE_AND) begin
                        res.result = it.a_value & it.operand;
                    end else if (it.mode == MODE_XOR) begin
                        res.result = it.a_value ^ it.operand;
                    end else begin
                        res.result = it.a_value | it.operand;
                    end
                    res.zero_out  = (res.result == 8'd0);
                    res.sub_out   = 1'b0;
                    res.half_out  = (it.mode == MODE_AND);
                    res.carry_out = 1'b0;
                end
                MODE_INC: begin
                    res.result   = it.operand + 8'd1;
                    res.zero_out = (res.result == 8'd0);
                    res.sub_out  = 1'b0;
                    res.half_out = (it.operand[3:0] == 4'hF);
                end
                MODE_DEC: begin
                    res.result   = it.operand - 8'd1;
                    res.zero_out = (res.result == 8'd0);
                    res.sub_out  = 1'b1;
                    res.half_out = (it.operand[3:0] == 4'h0);
                end
                MODE_DAA: begin
                    adj = 8'd0;
                    if (it.sub_in) begin
                        if (it.half_in) adj = adj | DAA_LO_ADJ;
                        if (it.carry_in) adj = adj | DAA_HI_ADJ;
                        res.result = it.a_value - adj;
                    end else begin
                        if (it.half_in || it.a_value[3:0] > BCD_DIGIT_MAX) begin
                            adj = adj | DAA_LO_ADJ;
                        end
                        if (it.carry_in || it.a_value > BCD_BYTE_MAX) begin
                            adj           = adj | DAA_HI_ADJ;
                            res.carry_out = 1'b1;
                        end
                        res.result = it.a_value + adj;
                    end
                    res.zero_out = (res.result == 8'd0);
                    res.half_out = 1'b0;
                end
                MODE_CPL: begin
                    res.result   = ~it.a_value;
                    res.sub_out  = 1'b1;
                    res.half_out = 1'b1;
                end
                MODE_CCF: begin
                    res.sub_out   = 1'b0;
                    res.half_out  = 1'b0;
                    res.carry_out = ~it.carry_in;
                end
                MODE_BIT: begin
                    res.result   = it.operand;
                    res.zero_out = ~it.operand[it.bit_index];
                    res.sub_out  = 1'b0;
                    res.half_out = 1'b1;
                end
                MODE_RES: res.result = it.operand & ~(8'd1 << it.bit_index);
                MODE_SET: res.result = it.operand | (8'd1 << it.bit_index);
                default: begin
                    if (it.mode >= MODE_RLC && it.mode <= MODE_SWAP) begin
                        kind          = it.mode - MODE_RLC;
                        res.result    = shift_byte(kind[2:0], it.operand, it.carry_in, cy);
                        res.zero_out  = (res.result == 8'd0);
                        res.sub_out   = 1'b0;
                        res.half_out  = 1'b0;
                        res.carry_out = cy;
                    end else if (it.mode >= MODE_RLCA && it.mode <= MODE_RRA) begin
                        // The accumulator rotates always clear Z.
                        kind          = it.mode - MODE_RLCA;
                        res.result    = shift_byte(kind[2:0], it.a_value, it.carry_in, cy);
                        res.zero_out  = 1'b0;
                        res.sub_out   = 1'b0;
                        res.half_out  = 1'b0;
                        res.carry_out = cy;
                    end
                end
            endcase
            return res;
        endfunction

        function void note_item(input t_alu_in it);
            pending_results.push_back(predict_alu(it));
            items_noted++;
        endfunction

        function void check_result(input t_alu_out got);
            t_alu_out want;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result %02h z%0b n%0b h%0b c%0b with nothing pending",
                             got.result, got.zero_out, got.sub_out, got.half_out, got.carry_out);
                end
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (got.result !== want.result || got.zero_out !== want.zero_out ||
                got.sub_out !== want.sub_out || got.half_out !== want.half_out ||
                got.carry_out !== want.carry_out) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display({"Result %0d: expected %02h z%0b n%0b h%0b c%0b, ",
                              "got %02h z%0b n%0b h%0b c%0b"},
                             results_checked, want.result, want.zero_out, want.sub_out,
                             want.half_out, want.carry_out, got.result, got.zero_out,
                             got.sub_out, got.half_out, got.carry_out);
                end
            end
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_alu_in  i_item;
    logic     o_valid;
    t_alu_out o_result;
    int       cycle_count = 0;

    alu_result_board alu_board = new();

    eight_bit_alu_with_flags_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Accepted items and strobed results are both taken at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy === 1'b0) alu_board.note_item(i_item);
            if (o_valid === 1'b1) alu_board.check_result(o_result);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_alu_in make_item(input logic [4:0] mode, input logic [7:0] a,
                                          input logic [7:0] b, input logic [2:0] bi,
                                          input logic [3:0] flags);
        t_alu_in it;
        it.mode      = mode;
        it.a_value   = a;
        it.operand   = b;
        it.bit_index = bi;
        {it.zero_in, it.sub_in, it.half_in, it.carry_in} = flags;
        return it;
    endfunction

    // Leans on the byte values where carries, half carries and BCD limits sit.
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(15))
            0: v = 8'h00;
            1: v = 8'hFF;
            2: v = 8'h0F;
            3: v = 8'hF0;
            4: v = 8'h99;
            5: v = 8'h9A;
            6: v = 8'h80;
            7: v = 8'h01;
            default: v = 8'($urandom_range(255));
        endcase
        return v;
    endfunction

    function automatic t_alu_in random_item();
        logic [4:0] mode;
        if ($urandom_range(15) == 0) begin
            mode = 5'($urandom_range(MODE_LAST_UNUSED, MODE_FIRST_UNUSED));
        end else begin
            mode = 5'($urandom_range(MODE_RRA, MODE_ADD));
        end
        return make_item(mode, pick_byte(), pick_byte(), 3'($urandom_range(7)),
                         4'($urandom_range(15)));
    endfunction

    task automatic send_item(input t_alu_in it, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    initial begin
        int idle_pct[4];
        idle_pct = '{0, 49, 0, 18};
        start   <= 1'b0;
        i_item  <= '0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: carries and borrows at the byte edges, both DAA paths, flag pass-through.
        send_item(make_item(MODE_ADD, 8'hFF, 8'h01, 3'd0, 4'b0000), 0);
        send_item(make_item(MODE_ADD, 8'h00, 8'h00, 3'd0, 4'b1111), 0);
        send_item(make_item(MODE_ADC, 8'h0F, 8'h00, 3'd0, 4'b0001), 0);
        send_item(make_item(MODE_SUB, 8'h00, 8'h01, 3'd0, 4'b0000), 0);
        send_item(make_item(MODE_SBC, 8'h10, 8'h0F, 3'd0, 4'b0001), 0);
        send_item(make_item(MODE_CP, 8'h42, 8'h42, 3'd0, 4'b0000), 0);
        send_item(make_item(MODE_AND, 8'hF0, 8'h0F, 3'd0, 4'b0000), 0);
        send_item(make_item(MODE_XOR, 8'hFF, 8'hFF, 3'd0, 4'b0000), 0);
        send_item(make_item(MODE_OR, 8'h00, 8'h00, 3'd0, 4'b0000), 0);
        send_item(make_item(MODE_INC, 8'h00, 8'hFF, 3'd0, 4'b0001), 0);
        send_item(make_item(MODE_DEC, 8'h00, 8'h00, 3'd0, 4'b0000), 0);
        send_item(make_item(MODE_DEC, 8'h00, 8'h10, 3'd0, 4'b0001), 0);
        send_item(make_item(MODE_DAA, 8'h9A, 8'h00, 3'd0, 4'b0000), 0);
        send_item(make_item(MODE_DAA, 8'h15, 8'h00, 3'd0, 4'b0111), 0);
        send_item(make_item(MODE_CPL, 8'h55, 8'h00, 3'd0, 4'b1001), 0);
        send_item(make_item(MODE_CCF, 8'hAB, 8'h00, 3'd0, 4'b1111), 0);
        send_item(make_item(MODE_RLC, 8'h00, 8'h80, 3'd0, 4'b0000), 0);
        send_item(make_item(MODE_SWAP, 8'h00, 8'hF0, 3'd0, 4'b0001), 0);
        send_item(make_item(MODE_BIT, 8'h00, 8'h7F, 3'd7, 4'b0001), 0);
        send_item(make_item(MODE_RES, 8'h00, 8'hFF, 3'd0, 4'b1111), 0);
        send_item(make_item(MODE_SET, 8'h00, 8'h00, 3'd7, 4'b0000), 0);
        send_item(make_item(MODE_RLCA, 8'h00, 8'h00, 3'd0, 4'b1000), 0);
        send_item(make_item(MODE_RRA, 8'h01, 8'h00, 3'd0, 4'b0001), 0);
        send_item(make_item(MODE_LAST_UNUSED, 8'hFF, 8'h00, 3'd0, 4'b1010), 0);

        foreach (idle_pct[p]) begin
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_item(random_item(), idle_pct[p]);
            end
        end
        start <= 1'b0;

        while (alu_board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items over all operations and unused codes, sender gaps up to 49%%.",
                 alu_board.items_noted);
        $display("Checked %0d results; %0d bad, %0d never arrived.", alu_board.results_checked,
                 alu_board.mismatch_count, alu_board.pending_results.size());
        if (alu_board.mismatch_count == 0 && alu_board.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: eight_bit_alu_with_flags_top.f
design/eba_pkg.sv
design/eba_shift.sv
design/eba_core.sv
design/eight_bit_alu_with_flags_top.sv
tb/sv/eight_bit_alu_with_flags_top_tb.sv
